// ----- hdl/sqlips_pkg.sv -----
package sqlips_pkg;

	localparam int LONGEST_PATTERN_DEF = 7;
	localparam int PAT_COUNT = 26;
	localparam int PAT_MAX_LEN = 7;

	typedef logic [7:0] byte_t;
	typedef logic [8*PAT_MAX_LEN-1:0] pat_txt_t;
	typedef logic [2:0] pat_len_t;

	typedef struct packed {
		byte_t text_byte;
		logic  byte_valid;
		logic  end_of_text;
	} item_t;

	// text is right-aligned: the last character of a pattern sits in bits [7:0]
	localparam pat_txt_t PAT_TXT [PAT_COUNT] = '{
		pat_txt_t'("SELECT"), pat_txt_t'("INSERT"), pat_txt_t'("UPDATE"),
		pat_txt_t'("DELETE"), pat_txt_t'("DROP"), pat_txt_t'("CREATE"),
		pat_txt_t'("ALTER"), pat_txt_t'("EXEC"), pat_txt_t'("EXECUTE"),
		pat_txt_t'("UNION"), pat_txt_t'("DECLARE"), pat_txt_t'("CAST"),
		pat_txt_t'("CONVERT"), pat_txt_t'("SCRIPT"), pat_txt_t'("--"),
		pat_txt_t'("/*"), pat_txt_t'("*/"), pat_txt_t'("XP_"),
		pat_txt_t'("SP_"), pat_txt_t'("0X"), pat_txt_t'("'"),
		pat_txt_t'("\""), pat_txt_t'(";"), pat_txt_t'("="),
		pat_txt_t'("OR"), pat_txt_t'("AND")
	};

	localparam pat_len_t PAT_LEN [PAT_COUNT] = '{
		3'd6, 3'd6, 3'd6, 3'd6, 3'd4, 3'd6, 3'd5, 3'd4, 3'd7,
		3'd5, 3'd7, 3'd4, 3'd7, 3'd6, 3'd2, 3'd2, 3'd2, 3'd3,
		3'd3, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd3
	};

	// fold ASCII lower case to upper case, leave every other byte alone
	function automatic byte_t fold_ascii(input byte_t b);
		if (b inside {[8'h61:8'h7a]})
			return b - 8'd32;
		return b;
	endfunction

endpackage

// ----- hdl/sql_injection_pattern_scanner_top.sv -----
// A final request waits in the input register while the result register is
// full. Throughput: one request per cycle while no final request waits;
// all patterns are matched in one stage between the input register and the
// history/result registers. A pending result does not block requests that
// do not end a string. Reset (arst_n low, asynchronous): pipeline and output
// empty, history, byte count and hit flag cleared.
module sql_injection_pattern_scanner_top #(
	parameter int LONGEST_PATTERN = sqlips_pkg::LONGEST_PATTERN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sqlips_pkg::byte_t  text_byte,
	input  logic               byte_valid,
	input  logic               end_of_text,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               text_safe
);
	import sqlips_pkg::*;

	localparam int HIST  = LONGEST_PATTERN - 1;
	localparam int CNT_W = $clog2(LONGEST_PATTERN);

	item_t                   item_s1;
	logic                    valid_s1;
	logic                    advance;
	logic                    out_free;
	logic                    matcher_hit;
	logic                    match_hit;
	logic [HIST-1:0][7:0]    hist_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    hit_q;
	logic                    out_valid_q;
	logic                    text_safe_q;

	sqlips_in_stage u_in_stage (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.text_byte   (text_byte),
		.byte_valid  (byte_valid),
		.end_of_text (end_of_text),
		.item_s1     (item_s1),
		.valid_s1    (valid_s1),
		.advance     (advance)
	);

	sqlips_matcher #(
		.LONGEST_PATTERN (LONGEST_PATTERN)
	) u_matcher (
		.cur_byte (item_s1.text_byte),
		.hist     (hist_q),
		.hist_cnt (cnt_q),
		.hit      (matcher_hit)
	);

	assign out_free  = !out_valid_q || out_ready;
	// hold a final request in s1 until the result register is free
	assign advance   = valid_s1 && (!item_s1.end_of_text || out_free);
	assign match_hit = item_s1.byte_valid && matcher_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
			cnt_q  <= '0;
			hit_q  <= 1'b0;
		end else if (advance) begin
			if (item_s1.end_of_text) begin
				hist_q <= '0;
				cnt_q  <= '0;
				hit_q  <= 1'b0;
			end else if (item_s1.byte_valid) begin
				hist_q <= {hist_q[HIST-2:0], item_s1.text_byte};
				if (cnt_q < CNT_W'(HIST))
					cnt_q <= cnt_q + 1'b1;
				hit_q <= hit_q | match_hit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && item_s1.end_of_text) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.end_of_text)
			text_safe_q <= !(hit_q | match_hit);
	end

	assign out_valid = out_valid_q;
	assign text_safe = text_safe_q;

`ifndef SYNTHESIS
	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.end_of_text |=> !hit_q && cnt_q == '0)
		else $error("state not cleared after end of string");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(HIST))
		else $error("byte count beyond history depth");

	a_hit_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		hit_q |-> cnt_q != '0)
		else $error("hit flag set with empty history");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance && item_s1.end_of_text))
		else $error("result raised without a final request");
`endif

endmodule

// ----- hdl/sqlips_in_stage.sv -----
module sqlips_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sqlips_pkg::byte_t   text_byte,
	input  logic                byte_valid,
	input  logic                end_of_text,
	output sqlips_pkg::item_t   item_s1,
	output logic                valid_s1,
	input  logic                advance
);
	import sqlips_pkg::*;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// fold on the way in so the window only ever holds folded bytes
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.text_byte   <= fold_ascii(text_byte);
			item_s1.byte_valid  <= byte_valid;
			item_s1.end_of_text <= end_of_text;
		end
	end

endmodule

// ----- hdl/sqlips_matcher.sv -----
module sqlips_matcher #(
	parameter int LONGEST_PATTERN = sqlips_pkg::LONGEST_PATTERN_DEF
) (
	input  sqlips_pkg::byte_t                        cur_byte,
	input  logic [LONGEST_PATTERN-2:0][7:0]          hist,
	input  logic [$clog2(LONGEST_PATTERN)-1:0]       hist_cnt,
	output logic                                     hit
);
	import sqlips_pkg::*;

	logic [PAT_MAX_LEN-1:0][7:0] win;

	always_comb begin
		win[0] = cur_byte;
		for (int i = 1; i < PAT_MAX_LEN; i++)
			win[i] = hist[i-1];
	end

	// every pattern up to LONGEST_PATTERN long checked in parallel against the window ending at the new byte
	always_comb begin
		logic ok;
		hit = 1'b0;
		for (int p = 0; p < PAT_COUNT; p++) begin
			ok = (int'(PAT_LEN[p]) <= LONGEST_PATTERN) &&
			     (int'(hist_cnt) + 1 >= int'(PAT_LEN[p]));
			for (int i = 0; i < PAT_MAX_LEN; i++) begin
				if (i < int'(PAT_LEN[p]) && win[i] != PAT_TXT[p][8*i +: 8])
					ok = 1'b0;
			end
			hit = hit | ok;
		end
	end

endmodule
